/* rtl/sequenced_reading_queue_top_defines.svh */
// ---------------------------------------------------------------------------
// Sequenced reading queue: assertion macros
// Shared property wrappers for the checker; clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef SEQUENCED_READING_QUEUE_TOP_DEFINES_SVH
`define SEQUENCED_READING_QUEUE_TOP_DEFINES_SVH

// plain property, sampled on clk
`define SRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition this cycle implies consequence on the next cycle
`define SRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/srq_pkg.sv */
// ---------------------------------------------------------------------------
// srq_pkg
// Types, codes and word layouts for the sequenced reading queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int BATCH_MAX_DEF   = 16;

	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;
	localparam int SEQ_W   = 32;
	localparam int TS_W    = 32;
	localparam int HR_W    = 8;
	localparam int STEPS_W = 32;
	localparam int IDX_W   = 6;
	localparam int QCNT_W  = 7;
	localparam int TOTAL_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_RECORD  = 3'd0,
		CMD_PEEK    = 3'd1,
		CMD_DROP    = 3'd2,
		CMD_BATCH   = 3'd3,
		CMD_RESET   = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_RANGE   = 2'd1,
		STAT_SKIPPED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// first field in the highest bits
	typedef struct packed {
		logic [1:0]         pad;
		logic [SEQ_W-1:0]   ack_seq;
		logic [IDX_W-1:0]   index;
		logic [STEPS_W-1:0] steps_total;
		logic [HR_W-1:0]    pulse_bpm;
		logic [TS_W-1:0]    timestamp;
	} in_word_t;

	typedef struct packed {
		logic               pad;
		logic               overwrote_oldest;
		logic [TOTAL_W-1:0] uploaded_total;
		logic [QCNT_W-1:0]  dropped;
		logic [QCNT_W-1:0]  queue_count;
		logic [STEPS_W-1:0] entry_steps;
		logic [HR_W-1:0]    entry_heart;
		logic [TS_W-1:0]    entry_time;
		logic [SEQ_W-1:0]   entry_seq;
	} out_word_t;

	// one ring entry as stored in the entry memory
	typedef struct packed {
		logic [SEQ_W-1:0]   seq;
		logic [TS_W-1:0]    stamp;
		logic [HR_W-1:0]    heart;
		logic [STEPS_W-1:0] steps;
	} entry_t;

	localparam int IN_DATA_W  = $bits(in_word_t);
	localparam int OUT_DATA_W = $bits(out_word_t);
	localparam int ENTRY_W    = $bits(entry_t);

endpackage

`default_nettype wire

/* rtl/sequenced_reading_queue_top.sv */
// ---------------------------------------------------------------------------
// sequenced_reading_queue_top
// Ring queue of sequence-numbered sensor readings with ack-driven release.
// ---------------------------------------------------------------------------
// Each command word passes through ST_IDLE, which captures it and issues the
// entry memory read at the addressed slot, and ST_EXEC, which resolves the
// command, writes the entry memory back and loads the output register. The
// entry memory read is registered for use in ST_EXEC; the next word is
// taken as soon as the result is in the output register, even if it has not
// been taken yet, and the block waits only while a second result has nowhere
// to go. Drop through is resolved in one step, since held entries carry
// consecutive sequence numbers ending one below the next number to issue.
// Entry contents are not cleared by reset; only held entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sequenced_reading_queue_top #(
	parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF,
	parameter int BATCH_MAX   = srq_pkg::BATCH_MAX_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// timestamp, pulse_bpm, steps_total, index, ack_seq, 2 bits zero fill
	input  wire [srq_pkg::IN_DATA_W-1:0]     s_tdata,
	// cmd
	input  wire [srq_pkg::CMD_W-1:0]         s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// entry_seq, entry_time, entry_heart, entry_steps, queue_count, dropped,
	// uploaded_total, overwrote_oldest, 1 bit zero fill
	output logic [srq_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status
	output logic [srq_pkg::STAT_W-1:0]       m_tuser
);

	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int OFF_W     = (CNT_W > srq_pkg::IDX_W) ? CNT_W : srq_pkg::IDX_W;
	localparam int SUM_W     = OFF_W + 1;
	localparam int BATCH_CAP = (BATCH_MAX > QUEUE_DEPTH) ? QUEUE_DEPTH : BATCH_MAX;

	// head plus offset, folded back into the ring
	function automatic logic [PTR_W-1:0] slot_wrap(input logic [PTR_W-1:0] base,
			input logic [OFF_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			sum = sum - SUM_W'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	srq_pkg::state_t     state_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [srq_pkg::SEQ_W-1:0]   next_seq_q;
	logic [srq_pkg::STEPS_W-1:0] baseline_q;
	logic [srq_pkg::TOTAL_W-1:0] acked_q;

	srq_pkg::cmd_t       cmd_s1;
	srq_pkg::in_word_t   in_s1;
	logic [srq_pkg::SEQ_W-1:0]   head_seq_s1;

	srq_pkg::out_word_t  out_q;
	srq_pkg::status_t    status_q;
	logic                out_valid_q;

	srq_pkg::in_word_t   in_w;
	logic                in_acc;
	logic                exec_go;
	logic [PTR_W-1:0]    rd_addr;
	logic [srq_pkg::ENTRY_W-1:0] rd_data;
	srq_pkg::entry_t     rd_entry;

	// resolved next values
	logic [PTR_W-1:0]    head_d;
	logic [CNT_W-1:0]    count_d;
	logic [srq_pkg::SEQ_W-1:0]   next_seq_d;
	logic [srq_pkg::STEPS_W-1:0] baseline_d;
	logic [srq_pkg::TOTAL_W-1:0] acked_d;
	srq_pkg::out_word_t  out_d;
	srq_pkg::status_t    status_d;
	logic                wr_en;
	logic [PTR_W-1:0]    wr_addr;
	srq_pkg::entry_t     wr_entry;

	assign in_w     = srq_pkg::in_word_t'(s_tdata);
	assign s_tready = (state_q == srq_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign exec_go  = (state_q == srq_pkg::ST_EXEC) && (!out_valid_q || m_tready);
	assign rd_addr  = slot_wrap(head_q, OFF_W'(in_w.index));
	assign rd_entry = srq_pkg::entry_t'(rd_data);

	srq_ram #(
		.WIDTH(srq_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (in_acc),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		logic [srq_pkg::STEPS_W-1:0] delta;
		logic [srq_pkg::SEQ_W-1:0]   diff;
		logic [CNT_W-1:0]            drop_n;
		logic                        full;

		delta  = (in_s1.steps_total >= baseline_q) ? in_s1.steps_total - baseline_q
							   : in_s1.steps_total;
		diff   = in_s1.ack_seq - head_seq_s1;
		drop_n = '0;
		full   = (count_q >= CNT_W'(QUEUE_DEPTH));

		head_d     = head_q;
		count_d    = count_q;
		next_seq_d = next_seq_q;
		baseline_d = baseline_q;
		acked_d    = acked_q;
		status_d   = srq_pkg::STAT_OK;
		out_d      = '0;
		wr_en      = 1'b0;
		wr_addr    = full ? head_q : slot_wrap(head_q, OFF_W'(count_q));
		wr_entry   = '{seq: next_seq_q, stamp: in_s1.timestamp,
			       heart: in_s1.pulse_bpm, steps: delta};

		unique case (cmd_s1)
			srq_pkg::CMD_RECORD: begin
				if (in_s1.timestamp == '0) begin
					status_d = srq_pkg::STAT_SKIPPED;
				end else begin
					wr_en      = exec_go;
					baseline_d = in_s1.steps_total;
					next_seq_d = next_seq_q + 1'b1;
					if (full) begin
						// oldest slot is reused in place
						head_d = slot_wrap(head_q, OFF_W'(1));
						out_d.overwrote_oldest = 1'b1;
					end else begin
						count_d = count_q + 1'b1;
					end
					out_d.entry_seq   = next_seq_q;
					out_d.entry_time  = in_s1.timestamp;
					out_d.entry_heart = in_s1.pulse_bpm;
					out_d.entry_steps = delta;
				end
			end
			srq_pkg::CMD_PEEK: begin
				if (OFF_W'(in_s1.index) >= OFF_W'(count_q)) begin
					status_d = srq_pkg::STAT_RANGE;
				end else begin
					out_d.entry_seq   = rd_entry.seq;
					out_d.entry_time  = rd_entry.stamp;
					out_d.entry_heart = rd_entry.heart;
					out_d.entry_steps = rd_entry.steps;
				end
			end
			srq_pkg::CMD_DROP: begin
				// held sequence numbers run head_seq .. head_seq+count-1;
				// an all-ones ack also covers anything past the wrap to zero
				if (count_q != '0 && in_s1.ack_seq >= head_seq_s1) begin
					if (&in_s1.ack_seq) begin
						drop_n = count_q;
					end else if (diff < srq_pkg::SEQ_W'(count_q)) begin
						drop_n = CNT_W'(diff) + 1'b1;
					end else begin
						drop_n = count_q;
					end
				end
				head_d  = slot_wrap(head_q, OFF_W'(drop_n));
				count_d = count_q - drop_n;
				acked_d = acked_q + srq_pkg::TOTAL_W'(drop_n);
			end
			srq_pkg::CMD_BATCH: begin
				drop_n  = (count_q > CNT_W'(BATCH_CAP)) ? CNT_W'(BATCH_CAP) : count_q;
				head_d  = slot_wrap(head_q, OFF_W'(drop_n));
				count_d = count_q - drop_n;
				acked_d = acked_q + srq_pkg::TOTAL_W'(drop_n);
			end
			srq_pkg::CMD_RESET: begin
				head_d  = '0;
				count_d = '0;
				acked_d = '0;
			end
			default: begin
			end
		endcase

		out_d.queue_count    = srq_pkg::QCNT_W'(count_d);
		out_d.dropped        = srq_pkg::QCNT_W'(drop_n);
		out_d.uploaded_total = acked_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srq_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			next_seq_q  <= srq_pkg::SEQ_W'(1);
			baseline_q  <= '0;
			acked_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				srq_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= srq_pkg::ST_EXEC;
					end
				end
				srq_pkg::ST_EXEC: begin
					if (exec_go) begin
						state_q <= srq_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= srq_pkg::ST_IDLE;
				end
			endcase

			if (exec_go) begin
				head_q      <= head_d;
				count_q     <= count_d;
				next_seq_q  <= next_seq_d;
				baseline_q  <= baseline_d;
				acked_q     <= acked_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1      <= srq_pkg::cmd_t'(s_tuser);
			in_s1       <= in_w;
			head_seq_s1 <= next_seq_q - srq_pkg::SEQ_W'(count_q);
		end
		if (exec_go) begin
			out_q    <= out_d;
			status_q <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = status_q;

endmodule

`default_nettype wire

/* rtl/srq_ram.sv */
// ---------------------------------------------------------------------------
// srq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                       clk,
	input  wire                       wr_en,
	input  wire [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire [WIDTH-1:0]           wr_data,
	input  wire                       rd_en,
	input  wire [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/srq_checker.sv */
// ---------------------------------------------------------------------------
// srq_checker
// Port-level checks for the sequenced reading queue, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sequenced_reading_queue_top_defines.svh"

module srq_checker #(
	parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF
) (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_tvalid,
	input wire                             s_tready,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [srq_pkg::OUT_DATA_W-1:0]   m_tdata,
	input wire [srq_pkg::STAT_W-1:0]       m_tuser
);

	srq_pkg::out_word_t out_w;
	logic               in_acc;
	logic               out_acc;
	logic [1:0]         pend_q;

	assign out_w   = srq_pkg::out_word_t'(m_tdata);
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// words taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (!in_acc && out_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`SRQ_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	`SRQ_ASSERT(a_no_spurious, out_acc |-> pend_q != 2'd0, "result without a pending word")

	`SRQ_ASSERT(a_fail_blank, m_tvalid && m_tuser != srq_pkg::STAT_OK |->
		out_w.entry_seq == '0 && out_w.entry_steps == '0 && out_w.dropped == '0 &&
		!out_w.overwrote_oldest, "failed command reported entry data")

	`SRQ_ASSERT(a_overwrite_full, m_tvalid && out_w.overwrote_oldest |->
		out_w.queue_count == srq_pkg::QCNT_W'(QUEUE_DEPTH), "overwrite while not full")

endmodule

bind sequenced_reading_queue_top srq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_srq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: sequenced reading queue testbench
// Drives command words into the reading queue and compares every result word
// with a local predictor of the ring, its sequence numbers, step deltas and
// acknowledge counts. Directed corner words first, then random mixes that
// fill, churn and drain the ring, with random gaps on both streams.
// ---------------------------------------------------------------------------

module tb_top;

	localparam int RING_DEPTH     = srq_pkg::QUEUE_DEPTH_DEF;
	localparam int BATCH_LIMIT    = srq_pkg::BATCH_MAX_DEF;
	localparam int RANDOM_WORDS   = 1650;
	localparam int MIX_SPAN       = 150;
	localparam int IDLE_PCT       = 18;
	localparam int CALM_FIRST     = 1500;
	localparam int CALM_LAST      = 3000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int LIMIT_CYCLES   = 200000;

	localparam logic [srq_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'(srq_pkg::CMD_RESET) + 3'd1;
	localparam logic [srq_pkg::CMD_W-1:0] CMD_SPARE_LAST  = '1;

	typedef enum {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

	typedef struct {
		logic [srq_pkg::CMD_W-1:0] op;
		srq_pkg::in_word_t         payload;
	} cmd_word_t;

	typedef struct packed {
		srq_pkg::status_t   status;
		srq_pkg::out_word_t data;
	} reading_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [srq_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [srq_pkg::CMD_W-1:0]      s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [srq_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [srq_pkg::STAT_W-1:0]     m_tuser;

	sequenced_reading_queue_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predicted ring contents and registers
	srq_pkg::entry_t               ring[RING_DEPTH];
	int                            ring_head;
	int                            ring_count;
	logic [srq_pkg::SEQ_W-1:0]     seq_next;
	logic [srq_pkg::STEPS_W-1:0]   step_base;
	logic [srq_pkg::TOTAL_W-1:0]   acked_sum;

	cmd_word_t                     queued_words[$];
	reading_result_t               expected_results[$];
	int                            mismatches;
	int                            cycle_count;
	logic                          word_taken;
	logic [srq_pkg::STEPS_W-1:0]   step_counter;
	cmd_word_t                     drive_word;

	function automatic reading_result_t predict_reading_result(
			logic [srq_pkg::CMD_W-1:0] op, srq_pkg::in_word_t w);
		reading_result_t             r;
		logic [srq_pkg::STEPS_W-1:0] delta;
		int                          slot;
		int                          n;
		r = '0;
		r.status = srq_pkg::STAT_OK;
		case (op)
			srq_pkg::CMD_RECORD: begin
				if (w.timestamp == '0) begin
					r.status = srq_pkg::STAT_SKIPPED;
				end else begin
					delta = (w.steps_total >= step_base) ? w.steps_total - step_base
						: w.steps_total;
					step_base = w.steps_total;
					if (ring_count >= RING_DEPTH) begin
						ring_head = (ring_head + 1) % RING_DEPTH;
						ring_count--;
						r.data.overwrote_oldest = 1'b1;
					end
					slot = (ring_head + ring_count) % RING_DEPTH;
					ring[slot] = '{seq: seq_next, stamp: w.timestamp,
						heart: w.pulse_bpm, steps: delta};
					ring_count++;
					r.data.entry_seq   = seq_next;
					r.data.entry_time  = w.timestamp;
					r.data.entry_heart = w.pulse_bpm;
					r.data.entry_steps = delta;
					seq_next = seq_next + 1;
				end
			end
			srq_pkg::CMD_PEEK: begin
				if (int'(w.index) >= ring_count) begin
					r.status = srq_pkg::STAT_RANGE;
				end else begin
					slot = (ring_head + int'(w.index)) % RING_DEPTH;
					r.data.entry_seq   = ring[slot].seq;
					r.data.entry_time  = ring[slot].stamp;
					r.data.entry_heart = ring[slot].heart;
					r.data.entry_steps = ring[slot].steps;
				end
			end
			srq_pkg::CMD_DROP: begin
				n = 0;
				while (ring_count > 0 && ring[ring_head].seq <= w.ack_seq) begin
					ring_head = (ring_head + 1) % RING_DEPTH;
					ring_count--;
					n++;
				end
				r.data.dropped = srq_pkg::QCNT_W'(n);
				acked_sum = acked_sum + srq_pkg::TOTAL_W'(n);
			end
			srq_pkg::CMD_BATCH: begin
				n = (ring_count < BATCH_LIMIT) ? ring_count : BATCH_LIMIT;
				ring_head = (ring_head + n) % RING_DEPTH;
				ring_count -= n;
				r.data.dropped = srq_pkg::QCNT_W'(n);
				acked_sum = acked_sum + srq_pkg::TOTAL_W'(n);
			end
			srq_pkg::CMD_RESET: begin
				ring_head = 0;
				ring_count = 0;
				acked_sum = '0;
			end
			default: ;
		endcase
		r.data.queue_count    = srq_pkg::QCNT_W'(ring_count);
		r.data.uploaded_total = acked_sum;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void push_word(logic [srq_pkg::CMD_W-1:0] op,
			logic [srq_pkg::TS_W-1:0] ts, logic [srq_pkg::HR_W-1:0] hr,
			logic [srq_pkg::STEPS_W-1:0] steps, logic [srq_pkg::IDX_W-1:0] idx,
			logic [srq_pkg::SEQ_W-1:0] ack);
		cmd_word_t w;
		w.op = op;
		w.payload = '0;
		w.payload.timestamp   = ts;
		w.payload.pulse_bpm   = hr;
		w.payload.steps_total = steps;
		w.payload.index       = idx;
		w.payload.ack_seq     = ack;
		queued_words.push_back(w);
	endfunction

	// random word shaped by the current predicted fill level
	task automatic add_random_word(mix_t mix);
		int                          r;
		int                          rec_pct, peek_pct, drop_pct, batch_pct, clr_pct;
		logic [srq_pkg::CMD_W-1:0]   op;
		logic [srq_pkg::TS_W-1:0]    ts;
		logic [srq_pkg::IDX_W-1:0]   idx;
		logic [srq_pkg::SEQ_W-1:0]   ack;
		logic [srq_pkg::SEQ_W-1:0]   head_seq;
		case (mix)
			MIX_FILL:  begin rec_pct = 80; peek_pct = 10; drop_pct = 4;  batch_pct = 2;  clr_pct = 1; end
			MIX_EVEN:  begin rec_pct = 45; peek_pct = 25; drop_pct = 15; batch_pct = 8;  clr_pct = 3; end
			default:   begin rec_pct = 30; peek_pct = 25; drop_pct = 22; batch_pct = 15; clr_pct = 4; end
		endcase
		r = $urandom_range(99);
		if (r < rec_pct)                                          op = srq_pkg::CMD_RECORD;
		else if (r < rec_pct + peek_pct)                          op = srq_pkg::CMD_PEEK;
		else if (r < rec_pct + peek_pct + drop_pct)               op = srq_pkg::CMD_DROP;
		else if (r < rec_pct + peek_pct + drop_pct + batch_pct)   op = srq_pkg::CMD_BATCH;
		else if (r < rec_pct + peek_pct + drop_pct + batch_pct + clr_pct)
			op = srq_pkg::CMD_RESET;
		else op = CMD_SPARE_LAST - 3'($urandom_range(CMD_SPARE_LAST - CMD_SPARE_FIRST));

		// counter mostly climbs; sometimes it goes back or jumps to an extreme
		r = $urandom_range(99);
		if (r < 75)      step_counter = step_counter + $urandom_range(300);
		else if (r < 85) step_counter = $urandom;
		else if (r < 92) step_counter = step_counter - $urandom_range(1, 50);
		else if (r < 96) step_counter = '0;
		else             step_counter = '1;

		ts = $urandom;
		r = $urandom_range(99);
		if (r < 4)       ts = '0;
		else if (r < 6) ts = '1;
		else if (ts == '0) ts = 1;

		idx = srq_pkg::IDX_W'($urandom);
		if ($urandom_range(99) < 70 && ring_count > 0)
			idx = srq_pkg::IDX_W'($urandom_range(ring_count - 1));
		else if ($urandom_range(99) < 30)
			idx = srq_pkg::IDX_W'(ring_count + $urandom_range(2));

		head_seq = seq_next - ring_count;
		r = $urandom_range(99);
		if (r < 60)      ack = head_seq + $urandom_range(ring_count + 1) - 1;
		else if (r < 75) ack = $urandom;
		else if (r < 85) ack = '0;
		else if (r < 95) ack = '1;
		else             ack = seq_next - 1;

		push_word(op, ts, srq_pkg::HR_W'($urandom), step_counter, idx, ack);
	endtask

	// result checking and prediction, sampled at the rising edge
	always @(posedge clk) begin
		reading_result_t    want;
		srq_pkg::out_word_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no expectation pending");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					got = srq_pkg::out_word_t'(m_tdata);
					check_field("status", 32'(want.status), 32'(m_tuser));
					check_field("entry_seq", want.data.entry_seq, got.entry_seq);
					check_field("entry_time", want.data.entry_time, got.entry_time);
					check_field("entry_heart", 32'(want.data.entry_heart), 32'(got.entry_heart));
					check_field("entry_steps", want.data.entry_steps, got.entry_steps);
					check_field("queue_count", 32'(want.data.queue_count), 32'(got.queue_count));
					check_field("dropped", 32'(want.data.dropped), 32'(got.dropped));
					check_field("uploaded_total", want.data.uploaded_total, got.uploaded_total);
					check_field("overwrote_oldest", 32'(want.data.overwrote_oldest),
						32'(got.overwrote_oldest));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_reading_result(s_tuser,
					srq_pkg::in_word_t'(s_tdata)));
			word_taken <= s_tvalid && s_tready;
		end else begin
			word_taken <= 1'b0;
		end
	end

	// input and output stream driving on the falling edge
	always @(negedge clk) begin
		logic calm;
		calm = cycle_count >= CALM_FIRST && cycle_count < CALM_LAST;
		if (arst_n) begin
			if (!s_tvalid || word_taken) begin
				if (queued_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					drive_word = queued_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= drive_word.payload;
					s_tuser  <= drive_word.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		mismatches   = 0;
		cycle_count  = 0;
		ring_head    = 0;
		ring_count   = 0;
		seq_next     = 1;
		step_base    = '0;
		acked_sum    = '0;
		step_counter = 60;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = srq_pkg::CMD_RECORD;
		m_tready     = 1'b0;
		word_taken   = 1'b0;

		// empty ring corners
		push_word(srq_pkg::CMD_PEEK,   32'd5, 8'd0, 32'd0, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_DROP,   32'd5, 8'd0, 32'd0, 6'd0, '1);
		push_word(srq_pkg::CMD_BATCH,  32'd5, 8'd0, 32'd0, 6'd0, 32'd0);
		// skipped record, then field extremes and a backwards counter
		push_word(srq_pkg::CMD_RECORD, 32'd0, 8'd80, 32'd1000, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_RECORD, 32'd1, 8'd0, 32'd0, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_RECORD, '1, '1, '1, '1, '1);
		push_word(srq_pkg::CMD_RECORD, 32'd100, 8'd72, 32'd5, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_RECORD, 32'd160, 8'd75, 32'd50, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_PEEK,   32'd0, 8'd0, 32'd0, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_PEEK,   32'd0, 8'd0, 32'd0, 6'd3, 32'd0);
		push_word(srq_pkg::CMD_PEEK,   32'd0, 8'd0, 32'd0, 6'd4, 32'd0);
		push_word(srq_pkg::CMD_PEEK,   '1, '1, '1, '1, '1);
		// drop through below the head, then part of the ring
		push_word(srq_pkg::CMD_DROP,   32'd0, 8'd0, 32'd0, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_DROP,   32'd0, 8'd0, 32'd0, 6'd0, 32'd2);
		push_word(CMD_SPARE_FIRST, '1, '1, '1, '1, '1);
		push_word(CMD_SPARE_LAST,  32'd9, 8'd9, 32'd9, 6'd9, 32'd9);
		push_word(srq_pkg::CMD_BATCH,  32'd0, 8'd0, 32'd0, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_RECORD, 32'd200, 8'd90, 32'd52, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_RECORD, 32'd260, 8'd95, 32'd58, 6'd0, 32'd0);
		// reset keeps the sequence and the step baseline
		push_word(srq_pkg::CMD_RESET,  32'd0, 8'd0, 32'd0, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_RECORD, 32'd320, 8'd99, 32'd60, 6'd0, 32'd0);
		push_word(srq_pkg::CMD_PEEK,   32'd0, 8'd0, 32'd0, 6'd0, 32'd0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		begin
			mix_t mix;
			mix = MIX_FILL;
			for (int n = 0; n < RANDOM_WORDS; n++) begin
				if (n % MIX_SPAN == 0 && n != 0)
					mix = mix_t'($urandom_range(2));
				while (queued_words.size() >= 2)
					@(negedge clk);
				add_random_word(mix);
			end
		end

		while (queued_words.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
